>>> sv/rbpa_pkg.sv
// Shared types and constants for the rotated blit pixel address converter.
// Depends on nothing; every other file in the project refers to it by scoped names.
package rbpa_pkg;

  // Field widths fixed by the request format.
  localparam int COORD_W = 13;
  localparam int DIM_W   = 14;
  localparam int OFS_W   = 26;
  localparam int PIX_W   = 32;
  localparam int SHF_W   = 5;
  localparam int NUM_CH  = 3;

  // Register stages between request acceptance and result.
  localparam int NUM_STAGES = 4;

  // APB register map: index i sits at byte address 4*i.
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_SCAN_STRIDE = 3'd1,
    REG_FRAME_WIDTH = 3'd2,
    REG_FRAME_HEIGHT = 3'd3,
    REG_CH_SHIFTS   = 3'd4,
    REG_RED_MASK    = 3'd5,
    REG_GREEN_MASK  = 3'd6,
    REG_BLUE_MASK   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  // Bit 2 of the mode register selects conversion by shifts and masks.
  localparam int MODE_CONV_BIT = 2;

  typedef struct packed {
    logic [2:0]         mode;
    logic [DIM_W-1:0]   scan_stride;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [29:0]        channel_shifts;
    logic [PIX_W-1:0]   red_mask;
    logic [PIX_W-1:0]   green_mask;
    logic [PIX_W-1:0]   blue_mask;
  } cfg_t;

  // Load enables of the pipeline stages, stage 0 first.
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctl_t;

endpackage

>>> sv/rbpa_stream_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on rbpa_pkg for field widths.
interface rbpa_in_if;
  logic                              valid;
  logic                              ready;
  logic [rbpa_pkg::COORD_W-1:0]      src_x;
  logic [rbpa_pkg::COORD_W-1:0]      src_y;
  logic [rbpa_pkg::COORD_W-1:0]      dst_x;
  logic [rbpa_pkg::COORD_W-1:0]      dst_y;
  logic [rbpa_pkg::DIM_W-1:0]        rect_width;
  logic [rbpa_pkg::DIM_W-1:0]        rect_height;
  logic [rbpa_pkg::DIM_W-1:0]        delta_pixels;
  logic [rbpa_pkg::COORD_W-1:0]      col;
  logic [rbpa_pkg::COORD_W-1:0]      row;
  logic [rbpa_pkg::PIX_W-1:0]        pixel_in;

  modport source (output valid, src_x, src_y, dst_x, dst_y, rect_width, rect_height,
                  delta_pixels, col, row, pixel_in, input ready);
  modport sink (input valid, src_x, src_y, dst_x, dst_y, rect_width, rect_height,
                delta_pixels, col, row, pixel_in, output ready);
endinterface

interface rbpa_out_if;
  logic                              valid;
  logic                              ready;
  logic [rbpa_pkg::OFS_W-1:0]        src_offset;
  logic [rbpa_pkg::OFS_W-1:0]        dst_offset;
  logic [rbpa_pkg::PIX_W-1:0]        pixel_out;
  logic                              position_ok;

  modport source (output valid, src_offset, dst_offset, pixel_out, position_ok,
                  input ready);
  modport sink (input valid, src_offset, dst_offset, pixel_out, position_ok,
                output ready);
endinterface

>>> sv/rotated_blit_pixel_address_convert.sv
// Rotated blit pixel address converter: source/destination offsets and pixel conversion.
// Four register stages (sums, rotation select, multiply, final add) lie between
// request acceptance and result valid.
// Throughput: one request per cycle; a stalled stage holds, empty stages still fill.
// Reset (rst_n, synchronous, active low) clears the stage valid bits and returns the
// registers to their reset values: sizes to 1, everything else to 0. No clearing pass.
module rotated_blit_pixel_address_convert #(
  parameter int MAX_DIM = 8192
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rbpa_in_if.sink                      in_chan,
  rbpa_out_if.source                   out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbpa_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int NS = rbpa_pkg::NUM_STAGES;

  rbpa_pkg::cfg_t       cfg;
  rbpa_pkg::pipe_ctl_t  ctl;
  logic [NS-1:0]        vld_r, vld_nxt;

  // Register file.
  rbpa_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A stage loads when it is empty or the stage after it loads too.
  always_comb begin
    ctl.en[NS-1] = !vld_r[NS-1] || out_chan.ready;
    for (int k = NS-2; k >= 0; k--) begin
      ctl.en[k] = !vld_r[k] || ctl.en[k+1];
    end
    vld_nxt[0] = ctl.en[0] ? in_chan.valid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = ctl.en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_chan.ready  = ctl.en[0];
  assign out_chan.valid = vld_r[NS-1];

  // Address datapath.
  rbpa_addr #(.MAX_DIM(MAX_DIM)) u_addr (
    .clk          (clk),
    .cfg          (cfg),
    .ctl          (ctl),
    .src_x        (in_chan.src_x),
    .src_y        (in_chan.src_y),
    .dst_x        (in_chan.dst_x),
    .dst_y        (in_chan.dst_y),
    .rect_width   (in_chan.rect_width),
    .rect_height  (in_chan.rect_height),
    .delta_pixels (in_chan.delta_pixels),
    .col          (in_chan.col),
    .row          (in_chan.row),
    .src_offset   (out_chan.src_offset),
    .dst_offset   (out_chan.dst_offset),
    .position_ok  (out_chan.position_ok)
  );

  // Pixel datapath.
  rbpa_pix u_pix (
    .clk       (clk),
    .cfg       (cfg),
    .ctl       (ctl),
    .pixel_in  (in_chan.pixel_in),
    .pixel_out (out_chan.pixel_out)
  );

endmodule

>>> sv/rbpa_cfg.sv
// APB register file holding mode, frame geometry and channel conversion settings.
// Depends on rbpa_pkg for the register map and the configuration struct.
module rbpa_cfg #(
  parameter int MAX_DIM = 8192
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbpa_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output rbpa_pkg::cfg_t               cfg
);

  rbpa_pkg::cfg_t            cfg_r;
  rbpa_pkg::reg_idx_t        reg_idx;
  logic                      wr_en;
  logic [rbpa_pkg::DIM_W-1:0] dim_val;

  assign pready  = 1'b1;
  assign reg_idx = rbpa_pkg::reg_idx_t'(paddr[rbpa_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // Size registers saturate at the largest supported dimension.
  always_comb begin
    dim_val = pwdata[rbpa_pkg::DIM_W-1:0];
    if (32'(dim_val) > 32'(MAX_DIM)) begin
      dim_val = rbpa_pkg::DIM_W'(MAX_DIM);
    end
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= '0;
      cfg_r.scan_stride    <= rbpa_pkg::DIM_W'(1);
      cfg_r.frame_width    <= rbpa_pkg::DIM_W'(1);
      cfg_r.frame_height   <= rbpa_pkg::DIM_W'(1);
      cfg_r.channel_shifts <= '0;
      cfg_r.red_mask       <= '0;
      cfg_r.green_mask     <= '0;
      cfg_r.blue_mask      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        rbpa_pkg::REG_MODE:         cfg_r.mode           <= pwdata[2:0];
        rbpa_pkg::REG_SCAN_STRIDE:  cfg_r.scan_stride    <= dim_val;
        rbpa_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width    <= dim_val;
        rbpa_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height   <= dim_val;
        rbpa_pkg::REG_CH_SHIFTS:    cfg_r.channel_shifts <= pwdata[29:0];
        rbpa_pkg::REG_RED_MASK:     cfg_r.red_mask       <= pwdata;
        rbpa_pkg::REG_GREEN_MASK:   cfg_r.green_mask     <= pwdata;
        rbpa_pkg::REG_BLUE_MASK:    cfg_r.blue_mask      <= pwdata;
      endcase
    end
  end

  // Read data is selected straight from the registers.
  always_comb begin
    unique case (reg_idx)
      rbpa_pkg::REG_MODE:         prdata = 32'(cfg_r.mode);
      rbpa_pkg::REG_SCAN_STRIDE:  prdata = 32'(cfg_r.scan_stride);
      rbpa_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_r.frame_width);
      rbpa_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_r.frame_height);
      rbpa_pkg::REG_CH_SHIFTS:    prdata = 32'(cfg_r.channel_shifts);
      rbpa_pkg::REG_RED_MASK:     prdata = cfg_r.red_mask;
      rbpa_pkg::REG_GREEN_MASK:   prdata = cfg_r.green_mask;
      rbpa_pkg::REG_BLUE_MASK:    prdata = cfg_r.blue_mask;
    endcase
  end

endmodule

>>> sv/rbpa_addr.sv
// Four-stage address datapath: coordinate sums, rotation select, multiply, final add.
// Depends on rbpa_pkg for widths, rotation codes and the stage enable struct.
module rbpa_addr #(
  parameter int MAX_DIM = 8192
) (
  input  logic                          clk,
  input  rbpa_pkg::cfg_t                cfg,
  input  rbpa_pkg::pipe_ctl_t           ctl,
  input  logic [rbpa_pkg::COORD_W-1:0]  src_x,
  input  logic [rbpa_pkg::COORD_W-1:0]  src_y,
  input  logic [rbpa_pkg::COORD_W-1:0]  dst_x,
  input  logic [rbpa_pkg::COORD_W-1:0]  dst_y,
  input  logic [rbpa_pkg::DIM_W-1:0]    rect_width,
  input  logic [rbpa_pkg::DIM_W-1:0]    rect_height,
  input  logic [rbpa_pkg::DIM_W-1:0]    delta_pixels,
  input  logic [rbpa_pkg::COORD_W-1:0]  col,
  input  logic [rbpa_pkg::COORD_W-1:0]  row,
  output logic [rbpa_pkg::OFS_W-1:0]    src_offset,
  output logic [rbpa_pkg::OFS_W-1:0]    dst_offset,
  output logic                          position_ok
);

  localparam int DW = rbpa_pkg::DIM_W;
  localparam int OW = rbpa_pkg::OFS_W;

  // Stage 0 registers.
  logic [DW-1:0] sum_y_r, sum_x_r, dsum_y_r, dsum_x_r, delta_r;
  logic          ok0_r;
  logic [DW-1:0] delta_sat;

  // Stage 1 registers.
  logic [OW-1:0] mop1_r, add1_r;
  logic [DW-1:0] dsum_y1_r, dsum_x1_r, delta1_r;
  logic          ok1_r;
  logic [OW-1:0] wy, hy, wx, hx, mop_nxt, add_nxt;

  // Stage 2 registers.
  logic [OW-1:0] prod2_r, add2_r, dprod2_r;
  logic [DW-1:0] dadd2_r;
  logic          ok2_r;
  logic [OW+DW-1:0] src_prod;
  logic [2*DW-1:0]  dst_prod;

  // Stage 3 registers.
  logic [OW-1:0] src_off_r, dst_off_r;
  logic          ok3_r;

  // Destination pitch saturates like the size registers.
  always_comb begin
    delta_sat = delta_pixels;
    if (32'(delta_pixels) > 32'(MAX_DIM)) begin
      delta_sat = DW'(MAX_DIM);
    end
  end

  // Stage 0: absolute coordinates and the bounds check.
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      sum_y_r  <= DW'(src_y) + DW'(row);
      sum_x_r  <= DW'(src_x) + DW'(col);
      dsum_y_r <= DW'(dst_y) + DW'(row);
      dsum_x_r <= DW'(dst_x) + DW'(col);
      delta_r  <= delta_sat;
      ok0_r    <= (DW'(col) < rect_width) && (DW'(row) < rect_height);
    end
  end

  // Stage 1: mirrored coordinates, then pick multiplicand and addend per rotation.
  always_comb begin
    wy = OW'(cfg.frame_width) - OW'(sum_y_r) - OW'(1);
    hy = OW'(cfg.frame_height) - OW'(sum_y_r) - OW'(1);
    wx = OW'(cfg.frame_width) - OW'(sum_x_r) - OW'(1);
    hx = OW'(cfg.frame_height) - OW'(sum_x_r) - OW'(1);
    unique case (rbpa_pkg::rot_t'(cfg.mode[1:0]))
      rbpa_pkg::ROT_0: begin
        mop_nxt = OW'(sum_y_r);
        add_nxt = OW'(sum_x_r);
      end
      rbpa_pkg::ROT_90: begin
        mop_nxt = OW'(sum_x_r);
        add_nxt = wy;
      end
      rbpa_pkg::ROT_180: begin
        mop_nxt = hy;
        add_nxt = wx;
      end
      rbpa_pkg::ROT_270: begin
        mop_nxt = hx;
        add_nxt = OW'(sum_y_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      mop1_r    <= mop_nxt;
      add1_r    <= add_nxt;
      dsum_y1_r <= dsum_y_r;
      dsum_x1_r <= dsum_x_r;
      delta1_r  <= delta_r;
      ok1_r     <= ok0_r;
    end
  end

  // Stage 2: row multiplies; only the low offset bits are kept.
  always_comb begin
    src_prod = (OW+DW)'(mop1_r) * (OW+DW)'(cfg.scan_stride);
    dst_prod = (2*DW)'(dsum_y1_r) * (2*DW)'(delta1_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      prod2_r  <= src_prod[OW-1:0];
      dprod2_r <= dst_prod[OW-1:0];
      add2_r   <= add1_r;
      dadd2_r  <= dsum_x1_r;
      ok2_r    <= ok1_r;
    end
  end

  // Stage 3: final adds into the output register.
  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      src_off_r <= prod2_r + add2_r;
      dst_off_r <= dprod2_r + OW'(dadd2_r);
      ok3_r     <= ok2_r;
    end
  end

  assign src_offset  = src_off_r;
  assign dst_offset  = dst_off_r;
  assign position_ok = ok3_r;

endmodule

>>> sv/rbpa_pix.sv
// Four-stage pixel datapath: left shifts, right shifts, mask and merge, output register.
// Depends on rbpa_pkg for widths, the mode bit and the stage enable struct.
module rbpa_pix (
  input  logic                        clk,
  input  rbpa_pkg::cfg_t              cfg,
  input  rbpa_pkg::pipe_ctl_t         ctl,
  input  logic [rbpa_pkg::PIX_W-1:0]  pixel_in,
  output logic [rbpa_pkg::PIX_W-1:0]  pixel_out
);

  localparam int PW = rbpa_pkg::PIX_W;
  localparam int NC = rbpa_pkg::NUM_CH;
  localparam int SW = rbpa_pkg::SHF_W;

  logic [PW-1:0] shl_r [NC];
  logic [PW-1:0] shr_r [NC];
  logic [PW-1:0] p0_r, p1_r, pix2_r, pix3_r;
  logic [PW-1:0] shl_nxt [NC];
  logic [PW-1:0] shr_nxt [NC];
  logic [PW-1:0] merged;

  // Per channel: left shift amount at bit 10*k, right shift five bits above.
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      shl_nxt[k] = pixel_in << cfg.channel_shifts[10*k +: SW];
      shr_nxt[k] = shl_r[k] >> cfg.channel_shifts[10*k+SW +: SW];
    end
  end

  // Stage 0: left shifts.
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      shl_r <= shl_nxt;
      p0_r  <= pixel_in;
    end
  end

  // Stage 1: right shifts.
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      shr_r <= shr_nxt;
      p1_r  <= p0_r;
    end
  end

  // Stage 2: mask, merge, and choose between converted and native pixel.
  assign merged = (shr_r[0] & cfg.red_mask) | (shr_r[1] & cfg.green_mask) |
                  (shr_r[2] & cfg.blue_mask);

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      pix2_r <= cfg.mode[rbpa_pkg::MODE_CONV_BIT] ? merged : p1_r;
    end
  end

  // Stage 3: output register.
  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      pix3_r <= pix2_r;
    end
  end

  assign pixel_out = pix3_r;

endmodule

>>> sv/rbpa_chk.sv
// Port-level checker for the rotated blit converter, bound to the top level.
// Depends on rbpa_pkg for the pipeline depth; sees only handshake ports.
module rbpa_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  localparam int NS  = rbpa_pkg::NUM_STAGES;
  localparam int CW  = $clog2(NS + 2);

  logic [CW-1:0] occ_r;
  logic          in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests in flight inside the block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + CW'(in_acc) - CW'(out_acc);
    end
  end

  // A result that is offered stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // No result without a request still in flight, and never more than the stage count.
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r <= CW'(NS)) && (!out_valid || occ_r != '0))
    else $error("result count does not match accepted requests");

  // A draining output never blocks the input side.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the output drains");

  // With the output ready behind it, an accepted request comes out as a result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind rotated_blit_pixel_address_convert rbpa_chk u_rbpa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);

>>> sim/rotated_blit_pixel_address_convert_tb.sv
// Testbench for the rotated blit pixel address converter: a scoreboard predicts
// every result from its own copy of the registers and checks it as it arrives.
// Depends on rbpa_pkg, the rbpa stream interfaces and the converter top level.
module rotated_blit_pixel_address_convert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIZE_LIMIT  = 8192;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic [rbpa_pkg::COORD_W-1:0] src_x;
    logic [rbpa_pkg::COORD_W-1:0] src_y;
    logic [rbpa_pkg::COORD_W-1:0] dst_x;
    logic [rbpa_pkg::COORD_W-1:0] dst_y;
    logic [rbpa_pkg::DIM_W-1:0]   rect_width;
    logic [rbpa_pkg::DIM_W-1:0]   rect_height;
    logic [rbpa_pkg::DIM_W-1:0]   delta_pixels;
    logic [rbpa_pkg::COORD_W-1:0] col;
    logic [rbpa_pkg::COORD_W-1:0] row;
    logic [rbpa_pkg::PIX_W-1:0]   pixel_in;
  } blit_req_t;

  typedef struct packed {
    logic [rbpa_pkg::OFS_W-1:0] src_offset;
    logic [rbpa_pkg::OFS_W-1:0] dst_offset;
    logic [rbpa_pkg::PIX_W-1:0] pixel_out;
    logic                       position_ok;
  } blit_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rbpa_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rbpa_in_if  in_chan ();
  rbpa_out_if out_chan ();

  rotated_blit_pixel_address_convert #(
    .MAX_DIM(SIZE_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Shadow registers and the queue of results still owed by the block.
  rbpa_pkg::cfg_t cfg_shadow;
  blit_res_t pending_results[$];
  int        errors = 0;
  int        sent_count = 0;
  int        checked_count = 0;
  int        setting_count = 0;
  int        cycles = 0;
  bit        src_idling = 1'b1;
  bit        sink_idling = 1'b1;
  int        hold_asked = 0;
  int        hold_taken = 0;
  int        stall_left = 0;

  always #6 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               pending_results.size());
      $display("rotated_blit_pixel_address_convert_tb: errors");
      $finish;
    end
  end

  // Size registers and the row delta clamp at the largest frame dimension.
  function automatic logic [rbpa_pkg::DIM_W-1:0] clamp_dim(logic [rbpa_pkg::DIM_W-1:0] v);
    return (v > SIZE_LIMIT) ? rbpa_pkg::DIM_W'(SIZE_LIMIT) : v;
  endfunction

  function automatic logic [rbpa_pkg::PIX_W-1:0] shift_mask(
      logic [rbpa_pkg::PIX_W-1:0] p, logic [4:0] shl, logic [4:0] shr,
      logic [rbpa_pkg::PIX_W-1:0] m);
    logic [rbpa_pkg::PIX_W-1:0] t;
    t = p << shl;
    t = t >> shr;
    return t & m;
  endfunction

  // Offsets are formed in 64-bit unsigned arithmetic, so negative terms wrap
  // in two's complement before the low 26 bits are kept.
  function automatic blit_res_t predict_pixel(blit_req_t q);
    blit_res_t  res;
    logic [63:0] sx, sy, dx, dy, c, r, s, w, h, dl, so, dofs;
    logic [29:0] sh;
    sx = 64'(q.src_x);
    sy = 64'(q.src_y);
    dx = 64'(q.dst_x);
    dy = 64'(q.dst_y);
    c  = 64'(q.col);
    r  = 64'(q.row);
    dl = 64'(clamp_dim(q.delta_pixels));
    s  = 64'(cfg_shadow.scan_stride);
    w  = 64'(cfg_shadow.frame_width);
    h  = 64'(cfg_shadow.frame_height);
    sh = cfg_shadow.channel_shifts;
    case (rbpa_pkg::rot_t'(cfg_shadow.mode[1:0]))
      rbpa_pkg::ROT_0:   so = (sy + r) * s + sx + c;
      rbpa_pkg::ROT_90:  so = (w - sy - 64'd1 - r) + (sx + c) * s;
      rbpa_pkg::ROT_180: so = (h - sy - 64'd1 - r) * s + (w - sx - 64'd1 - c);
      default:           so = (sy + r) + (h - sx - 64'd1 - c) * s;
    endcase
    dofs = (dy + r) * dl + dx + c;
    res.src_offset = so[rbpa_pkg::OFS_W-1:0];
    res.dst_offset = dofs[rbpa_pkg::OFS_W-1:0];
    if (cfg_shadow.mode[rbpa_pkg::MODE_CONV_BIT]) begin
      res.pixel_out = shift_mask(q.pixel_in, sh[4:0], sh[9:5], cfg_shadow.red_mask) |
                      shift_mask(q.pixel_in, sh[14:10], sh[19:15], cfg_shadow.green_mask) |
                      shift_mask(q.pixel_in, sh[24:20], sh[29:25], cfg_shadow.blue_mask);
    end else begin
      res.pixel_out = q.pixel_in;
    end
    res.position_ok = (q.col < q.rect_width) && (q.row < q.rect_height);
    return res;
  endfunction

  function automatic blit_req_t make_req(int sx, int sy, int dx, int dy, int w, int h,
                                         int dl, int c, int r,
                                         logic [rbpa_pkg::PIX_W-1:0] p);
    blit_req_t q;
    q.src_x = rbpa_pkg::COORD_W'(sx);
    q.src_y = rbpa_pkg::COORD_W'(sy);
    q.dst_x = rbpa_pkg::COORD_W'(dx);
    q.dst_y = rbpa_pkg::COORD_W'(dy);
    q.rect_width = rbpa_pkg::DIM_W'(w);
    q.rect_height = rbpa_pkg::DIM_W'(h);
    q.delta_pixels = rbpa_pkg::DIM_W'(dl);
    q.col = rbpa_pkg::COORD_W'(c);
    q.row = rbpa_pkg::COORD_W'(r);
    q.pixel_in = p;
    return q;
  endfunction

  // Shaped requests sit inside a mostly small rectangle, now and then one step
  // past its edge; the rest are raw noise over the full field widths.
  function automatic blit_req_t random_req(bit shaped);
    blit_req_t q;
    int unsigned w, h;
    q.src_x = rbpa_pkg::COORD_W'($urandom);
    q.src_y = rbpa_pkg::COORD_W'($urandom);
    q.dst_x = rbpa_pkg::COORD_W'($urandom);
    q.dst_y = rbpa_pkg::COORD_W'($urandom);
    q.pixel_in = $urandom;
    if (shaped) begin
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(1, SIZE_LIMIT) : $urandom_range(1, 64);
      h = ($urandom_range(0, 15) == 0) ? $urandom_range(1, SIZE_LIMIT) : $urandom_range(1, 64);
      q.rect_width = rbpa_pkg::DIM_W'(w);
      q.rect_height = rbpa_pkg::DIM_W'(h);
      q.delta_pixels = rbpa_pkg::DIM_W'($urandom_range(1, SIZE_LIMIT));
      q.col = rbpa_pkg::COORD_W'($urandom_range(0, w - 1));
      q.row = rbpa_pkg::COORD_W'($urandom_range(0, h - 1));
      if ($urandom_range(0, 11) == 0) q.col = rbpa_pkg::COORD_W'(w);
      if ($urandom_range(0, 11) == 0) q.row = rbpa_pkg::COORD_W'(h);
    end else begin
      q.rect_width = rbpa_pkg::DIM_W'($urandom);
      q.rect_height = rbpa_pkg::DIM_W'($urandom);
      q.delta_pixels = rbpa_pkg::DIM_W'($urandom);
      q.col = rbpa_pkg::COORD_W'($urandom);
      q.row = rbpa_pkg::COORD_W'($urandom);
    end
    return q;
  endfunction

  function automatic logic [31:0] mode_word(rbpa_pkg::rot_t rot, bit conv);
    logic [31:0] m;
    m = 32'(rot);
    m[rbpa_pkg::MODE_CONV_BIT] = conv;
    return m;
  endfunction

  function automatic logic [31:0] random_dim_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'(SIZE_LIMIT);
      3: return 32'h0000_3FFF;
      4: return $urandom;
      5: return 32'($urandom_range(1, 64));
      default: return 32'($urandom_range(1, SIZE_LIMIT));
    endcase
  endfunction

  function automatic logic [31:0] random_mask_word();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One APB write: setup cycle, access cycle until pready, then back to idle.
  task automatic write_reg(rbpa_pkg::reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      rbpa_pkg::REG_MODE:         cfg_shadow.mode = val[2:0];
      rbpa_pkg::REG_SCAN_STRIDE:  cfg_shadow.scan_stride = clamp_dim(val[rbpa_pkg::DIM_W-1:0]);
      rbpa_pkg::REG_FRAME_WIDTH:  cfg_shadow.frame_width = clamp_dim(val[rbpa_pkg::DIM_W-1:0]);
      rbpa_pkg::REG_FRAME_HEIGHT: cfg_shadow.frame_height =
                                    clamp_dim(val[rbpa_pkg::DIM_W-1:0]);
      rbpa_pkg::REG_CH_SHIFTS:    cfg_shadow.channel_shifts = val[29:0];
      rbpa_pkg::REG_RED_MASK:     cfg_shadow.red_mask = val;
      rbpa_pkg::REG_GREEN_MASK:   cfg_shadow.green_mask = val;
      default:                    cfg_shadow.blue_mask = val;
    endcase
  endtask

  task automatic load_settings(logic [31:0] mode, logic [31:0] stride, logic [31:0] width,
                               logic [31:0] height, logic [31:0] shifts, logic [31:0] red,
                               logic [31:0] green, logic [31:0] blue);
    write_reg(rbpa_pkg::REG_MODE, mode);
    write_reg(rbpa_pkg::REG_SCAN_STRIDE, stride);
    write_reg(rbpa_pkg::REG_FRAME_WIDTH, width);
    write_reg(rbpa_pkg::REG_FRAME_HEIGHT, height);
    write_reg(rbpa_pkg::REG_CH_SHIFTS, shifts);
    write_reg(rbpa_pkg::REG_RED_MASK, red);
    write_reg(rbpa_pkg::REG_GREEN_MASK, green);
    write_reg(rbpa_pkg::REG_BLUE_MASK, blue);
    setting_count++;
  endtask

  // Offer one request, with an optional idle burst first, and record its
  // predicted result once the block takes it.
  task automatic send_pixel(blit_req_t q);
    if (src_idling && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.src_x <= q.src_x;
    in_chan.src_y <= q.src_y;
    in_chan.dst_x <= q.dst_x;
    in_chan.dst_y <= q.dst_y;
    in_chan.rect_width <= q.rect_width;
    in_chan.rect_height <= q.rect_height;
    in_chan.delta_pixels <= q.delta_pixels;
    in_chan.col <= q.col;
    in_chan.row <= q.row;
    in_chan.pixel_in <= q.pixel_in;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.push_back(predict_pixel(q));
    sent_count++;
  endtask

  // Stop sending, wait for every owed result, then let the pipeline settle.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (rbpa_pkg::NUM_STAGES + 2) @(posedge clk);
  endtask

  // Result receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left--;
    end else if (hold_taken != hold_asked) begin
      out_chan.ready <= 1'b0;
      hold_taken = hold_asked;
      stall_left = HOLD_CYCLES - 1;
    end else if (sink_idling && $urandom_range(0, 9) == 0) begin
      out_chan.ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    blit_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got src %h dst %h pix %h ok %b",
                 $time, out_chan.src_offset, out_chan.dst_offset, out_chan.pixel_out,
                 out_chan.position_ok);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("src_offset", 32'(want.src_offset), 32'(out_chan.src_offset));
        check_field("dst_offset", 32'(want.dst_offset), 32'(out_chan.dst_offset));
        check_field("pixel_out", want.pixel_out, out_chan.pixel_out);
        check_field("position_ok", 32'(want.position_ok), 32'(out_chan.position_ok));
        checked_count++;
      end
    end
  end

  // Reset values: identity rotation, unit sizes, pixel passed through.
  task automatic test_reset_values();
    send_pixel(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0000));
    send_pixel(make_req(8191, 8191, 8191, 8191, 16383, 16383, 16383, 8191, 8191,
                        32'hFFFF_FFFF));
    drain_results();
  endtask

  // Every rotation with and without conversion, on the largest frame.
  task automatic test_rotations();
    logic [31:0] swap_shifts;
    swap_shifts = {2'b00, 5'd16, 5'd0, 5'd0, 5'd0, 5'd0, 5'd16};
    for (int k = 0; k < 8; k++) begin
      load_settings(mode_word(rbpa_pkg::rot_t'(k % 4), k >= 4), 32'(SIZE_LIMIT),
                    32'(SIZE_LIMIT), 32'(SIZE_LIMIT), swap_shifts, 32'h00FF_0000,
                    32'h0000_FF00, 32'h0000_00FF);
      send_pixel(make_req(8191, 8191, 8191, 8191, 8192, 8192, 8192, 8191, 8191,
                          32'h1234_5678));
      send_pixel(make_req(100, 37, 5, 9, 64, 48, 640, 63, 47, $urandom));
      drain_results();
    end
  endtask

  // Zero and oversized registers, zero and oversized delta, and positions
  // on the rectangle's edge or outside it.
  task automatic test_size_extremes();
    load_settings(mode_word(rbpa_pkg::ROT_90, 1'b1), 32'd0, 32'd0, 32'd0, 32'h3FFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(make_req(0, 0, 0, 0, 0, 0, 1, 0, 0, 32'hA5A5_5A5A));
    send_pixel(make_req(8191, 8191, 8191, 8191, 8192, 8192, 8192, 8191, 8191,
                        32'h8000_0001));
    drain_results();
    load_settings(mode_word(rbpa_pkg::ROT_270, 1'b0), 32'hFFFF_FFFF, 32'h0000_3FFF,
                  32'd8193, 32'd0, 32'd0, 32'd0, 32'd0);
    send_pixel(make_req(8191, 0, 17, 3, 4, 4, 0, 2, 2, 32'hDEAD_BEEF));
    send_pixel(make_req(0, 8191, 8191, 8191, 4, 4, 16383, 3, 3, 32'h0F0F_F0F0));
    drain_results();
    load_settings(mode_word(rbpa_pkg::ROT_180, 1'b1), 32'd640, 32'd640, 32'd480, $urandom,
                  32'h00FF_00FF, 32'h0000_FFFF, 32'hFF00_0000);
    send_pixel(make_req(10, 20, 30, 40, 16, 8, 640, 16, 3, 32'h0102_0304));
    send_pixel(make_req(10, 20, 30, 40, 16, 8, 640, 5, 8, 32'hFFFF_0000));
    drain_results();
  endtask

  // Hold the receiver off while the sender keeps pushing, so the pipeline
  // fills and backs up onto the request side.
  task automatic test_backpressure();
    src_idling = 1'b0;
    hold_asked++;
    for (int i = 0; i < 40; i++) send_pixel(random_req(1'b1));
    drain_results();
    src_idling = 1'b1;
  endtask

  // Random settings per phase; the first eight phases walk through every mode.
  task automatic test_random_settings();
    logic [31:0] mode;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode = (ph < 8) ? 32'(ph) : 32'($urandom_range(0, 7));
      load_settings(mode, random_dim_word(), random_dim_word(), random_dim_word(), $urandom,
                    random_mask_word(), random_mask_word(), random_mask_word());
      for (int i = 0; i < PHASE_ITEMS; i++) send_pixel(random_req($urandom_range(0, 4) != 0));
      drain_results();
    end
  endtask

  // Final stretch at full rate on both sides.
  task automatic test_quiet_tail();
    src_idling = 1'b0;
    sink_idling = 1'b0;
    load_settings(32'($urandom_range(0, 7)), random_dim_word(), random_dim_word(),
                  random_dim_word(), $urandom, random_mask_word(), random_mask_word(),
                  random_mask_word());
    for (int i = 0; i < 100; i++) send_pixel(random_req($urandom_range(0, 4) != 0));
  endtask

  initial begin
    cfg_shadow.mode = 3'd0;
    cfg_shadow.scan_stride = rbpa_pkg::DIM_W'(1);
    cfg_shadow.frame_width = rbpa_pkg::DIM_W'(1);
    cfg_shadow.frame_height = rbpa_pkg::DIM_W'(1);
    cfg_shadow.channel_shifts = 30'd0;
    cfg_shadow.red_mask = 32'd0;
    cfg_shadow.green_mask = 32'd0;
    cfg_shadow.blue_mask = 32'd0;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_chan.valid <= 1'b0;
    in_chan.src_x <= '0;
    in_chan.src_y <= '0;
    in_chan.dst_x <= '0;
    in_chan.dst_y <= '0;
    in_chan.rect_width <= '0;
    in_chan.rect_height <= '0;
    in_chan.delta_pixels <= '0;
    in_chan.col <= '0;
    in_chan.row <= '0;
    in_chan.pixel_in <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_rotations();
    test_size_extremes();
    test_backpressure();
    test_random_settings();
    test_quiet_tail();
    drain_results();

    $display("Sent %0d pixel requests and checked %0d results over %0d register settings,",
             sent_count, checked_count, setting_count);
    $display("covering all rotations with and without conversion, size extremes and stalls.");
    if (errors == 0) begin
      $display("rotated_blit_pixel_address_convert_tb: clean");
    end else begin
      $display("rotated_blit_pixel_address_convert_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/rbpa_pkg.sv
sv/rbpa_stream_if.sv
sv/rbpa_cfg.sv
sv/rbpa_addr.sv
sv/rbpa_pix.sv
sv/rotated_blit_pixel_address_convert.sv
sv/rbpa_chk.sv
sim/rotated_blit_pixel_address_convert_tb.sv
